// File: rtl/core/bcse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_pkg
// Shared types, widths and helpers for the contour segment extractor.
// ----------------------------------------------------------------------------
package bcse_pkg;

   localparam int PIXEL_W      = 8;
   localparam int ROW2_W       = 11;
   localparam int COL2_W       = 13;
   localparam int ROWS_CFG_W   = 11;
   localparam int COLS_CFG_W   = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 13;

   localparam int DEF_MAX_ROWS   = 1024;
   localparam int DEF_MAX_COLS   = 4096;
   localparam int RST_IMAGE_ROWS = 1024;
   localparam int RST_IMAGE_COLS = 4096;

   // cell queue between front and back
   localparam int CELL_Q_DEPTH = 4;
   localparam int CELL_Q_PTR_W = $clog2(CELL_Q_DEPTH);
   localparam int CELL_Q_LVL_W = $clog2(CELL_Q_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_ROWS = 1'b0,
      CSR_IMAGE_COLS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   typedef enum logic [1:0] {
      EDGE_TOP    = 2'd0,
      EDGE_RIGHT  = 2'd1,
      EDGE_BOTTOM = 2'd2,
      EDGE_LEFT   = 2'd3
   } edge_type;

   typedef struct packed {
      logic [ROW2_W-1:0] row2;
      logic [COL2_W-1:0] col2;
   } point_type;

   // last index of a dimension, the size clamped to [2, max_value]
   function automatic int unsigned clamp_last(input int unsigned value,
                                              input int unsigned max_value);
      int unsigned lim;
      begin
         if (value < 2) lim = 2;
         else if (value > max_value) lim = max_value;
         else lim = value;
         return lim - 1;
      end
   endfunction

endpackage

// File: rtl/core/bcse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_front
// Pixel intake: binarize, row/column counters, previous-column store and
// classification of each completed 2x2 cell into its crossed edges.
// ----------------------------------------------------------------------------
module bcse_front import bcse_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   localparam int ROW_W  = $clog2(MAX_ROWS),
   localparam int COL_W  = $clog2(MAX_COLS),
   localparam int CELL_W = ROW_W + COL_W + 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [PIXEL_W-1:0]      pixel_value,
   output logic                    full,
   input  csr_write_type           csr_write,
   input  logic [CELL_Q_LVL_W-1:0] q_level,
   output logic                    cell_push,
   output logic [CELL_W-1:0]       cell_data
);

   logic [ROW_W-1:0] rows_last_ff;
   logic [COL_W-1:0] cols_last_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_ff;

   logic             col_store [MAX_ROWS];
   logic             left_ff;

   logic             s1_valid_ff;
   logic             s1_cur_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             left_above_ff;
   logic             above_ff;

   logic             accept;
   logic             cur;
   logic [3:0]       hit;

   // room is reserved for the beat already in stage 1
   assign full   = (32'(q_level) + 32'(s1_valid_ff)) >= CELL_Q_DEPTH;
   assign accept = push && !full;
   assign cur    = |pixel_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_last_ff <= ROW_W'(clamp_last(RST_IMAGE_ROWS, MAX_ROWS));
         cols_last_ff <= COL_W'(clamp_last(RST_IMAGE_COLS, MAX_COLS));
      end else if (csr_write.valid) begin
         case (csr_index_type'(csr_write.index))
            CSR_IMAGE_ROWS: begin
               rows_last_ff <= ROW_W'(clamp_last(
                  32'(csr_write.data[ROWS_CFG_W-1:0]), MAX_ROWS));
            end
            CSR_IMAGE_COLS: begin
               cols_last_ff <= COL_W'(clamp_last(
                  32'(csr_write.data[COLS_CFG_W-1:0]), MAX_COLS));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (row_ff >= rows_last_ff) begin
            row_ff <= '0;
            if (col_ff >= cols_last_ff) col_ff <= '0;
            else col_ff <= col_ff + COL_W'(1);
         end else begin
            row_ff <= row_ff + ROW_W'(1);
         end
      end
   end

   // read-first: the read returns the previous column's bit for this row
   always_ff @(posedge clock) begin
      if (accept) begin
         col_store[row_ff] <= cur;
         left_ff           <= col_store[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff <= cur;
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         left_above_ff <= 1'b0;
         above_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            left_above_ff <= left_ff;
            above_ff      <= s1_cur_ff;
         end
      end
   end

   // corners: left_above top-left, above top-right, cur bottom-right,
   // left bottom-left; bit order top, right, bottom, left
   always_comb begin
      hit[0] = left_above_ff ^ above_ff;
      hit[1] = above_ff ^ s1_cur_ff;
      hit[2] = s1_cur_ff ^ left_ff;
      hit[3] = left_ff ^ left_above_ff;
   end

   assign cell_push = s1_valid_ff && (s1_row_ff != '0) && (s1_col_ff != '0)
                      && (hit != 4'b0000);
   assign cell_data = {s1_row_ff, s1_col_ff, hit};

endmodule

// File: rtl/core/bcse_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_fifo
// Short cell queue between the classifier and the segment emitter.
// ----------------------------------------------------------------------------
module bcse_fifo import bcse_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output logic [CELL_Q_LVL_W-1:0] level
);

   logic [WIDTH-1:0]        entry_ff [CELL_Q_DEPTH];
   logic [CELL_Q_PTR_W-1:0] wr_ptr_ff;
   logic [CELL_Q_PTR_W-1:0] rd_ptr_ff;
   logic [CELL_Q_LVL_W-1:0] level_ff;

   function automatic logic [CELL_Q_PTR_W-1:0] ptr_next(
      input logic [CELL_Q_PTR_W-1:0] ptr);
      begin
         if (ptr == CELL_Q_PTR_W'(CELL_Q_DEPTH - 1)) return '0;
         return ptr + CELL_Q_PTR_W'(1);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (pop) rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (push && !pop) level_ff <= level_ff + CELL_Q_LVL_W'(1);
         else if (pop && !push) level_ff <= level_ff - CELL_Q_LVL_W'(1);
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign level    = level_ff;

endmodule

// File: rtl/core/bcse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcse_back
// Segment emitter: turns a queued cell into one or two segments with
// doubled-unit midpoints and holds them in the result register.
// ----------------------------------------------------------------------------
module bcse_back import bcse_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS,
   localparam int ROW_W  = $clog2(MAX_ROWS),
   localparam int COL_W  = $clog2(MAX_COLS),
   localparam int CELL_W = ROW_W + COL_W + 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  logic [CELL_W-1:0] q_data,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [ROW2_W-1:0] start_row2,
   output logic [COL2_W-1:0] start_col2,
   output logic [ROW2_W-1:0] end_row2,
   output logic [COL2_W-1:0] end_col2,
   output logic              last_of_cell
);

   logic              phase_ff;
   logic              rsp_valid_ff;
   point_type         start_ff;
   point_type         end_ff;
   logic              last_ff;

   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [3:0]        hit;
   logic [ROW2_W-1:0] r2;
   logic [COL2_W-1:0] c2;
   logic              saddle;
   logic              load;
   edge_type          first_edge;
   edge_type          second_edge;
   logic              seg_last;

   function automatic edge_type low_edge(input logic [3:0] h);
      begin
         if (h[0]) return EDGE_TOP;
         if (h[1]) return EDGE_RIGHT;
         if (h[2]) return EDGE_BOTTOM;
         return EDGE_LEFT;
      end
   endfunction

   function automatic edge_type high_edge(input logic [3:0] h);
      begin
         if (h[3]) return EDGE_LEFT;
         if (h[2]) return EDGE_BOTTOM;
         if (h[1]) return EDGE_RIGHT;
         return EDGE_TOP;
      end
   endfunction

   function automatic point_type mid_point(input edge_type e,
                                           input logic [ROW2_W-1:0] rr,
                                           input logic [COL2_W-1:0] cc);
      point_type p;
      begin
         case (e)
            EDGE_TOP: begin
               p.row2 = rr - ROW2_W'(2);
               p.col2 = cc - COL2_W'(1);
            end
            EDGE_RIGHT: begin
               p.row2 = rr - ROW2_W'(1);
               p.col2 = cc;
            end
            EDGE_BOTTOM: begin
               p.row2 = rr;
               p.col2 = cc - COL2_W'(1);
            end
            default: begin
               p.row2 = rr - ROW2_W'(1);
               p.col2 = cc - COL2_W'(2);
            end
         endcase
         return p;
      end
   endfunction

   assign {row, col, hit} = q_data;
   assign r2     = ROW2_W'(row) << 1;
   assign c2     = COL2_W'(col) << 1;
   assign saddle = (hit == 4'b1111);
   assign load   = q_valid && (!rsp_valid_ff || pop);

   // saddle: top-right beat first, then bottom-left
   always_comb begin
      if (saddle && !phase_ff) begin
         first_edge  = EDGE_TOP;
         second_edge = EDGE_RIGHT;
         seg_last    = 1'b0;
      end else if (saddle) begin
         first_edge  = EDGE_BOTTOM;
         second_edge = EDGE_LEFT;
         seg_last    = 1'b1;
      end else begin
         first_edge  = low_edge(hit);
         second_edge = high_edge(hit);
         seg_last    = 1'b1;
      end
   end

   assign q_pop = load && seg_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff     <= !seg_last;
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         start_ff <= mid_point(first_edge, r2, c2);
         end_ff   <= mid_point(second_edge, r2, c2);
         last_ff  <= seg_last;
      end
   end

   assign empty        = !rsp_valid_ff;
   assign start_row2   = start_ff.row2;
   assign start_col2   = start_ff.col2;
   assign end_row2     = end_ff.row2;
   assign end_col2     = end_ff.col2;
   assign last_of_cell = last_ff;

endmodule

// File: rtl/core/binary_contour_segment_extractor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_contour_segment_extractor_unit
// Marching-squares contour extractor giving edge-midpoint segments.
// ----------------------------------------------------------------------------
// Pixels enter column-major on the push/full side, one beat per pixel; a
// nonzero byte is foreground. Each 2x2 cell that closes yields zero, one or
// two segment beats on the empty/pop side, last_of_cell marking the final
// beat of a cell. Coordinates are in half-pixel units.
// Throughput: one pixel per cycle while results drain as fast as they are
// made; a saddle cell takes two result beats from the emitter.
// A pixel's segments pass stage 1, the cell queue and the result register.
// A four-entry cell queue sits between the classifier and the emitter, so
// a stalled receiver only backs up input once queue and stage 1 are full.
// The config channel (valid/ready, always ready) writes image_rows (index 0)
// and image_cols (index 1); write them only while the block is idle.
// Reset sets rows 1024 and cols 4096 (clamped to the size parameters),
// clears counters and queues; the column store needs no clearing.
// ----------------------------------------------------------------------------
module binary_contour_segment_extractor_unit import bcse_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [PIXEL_W-1:0]    req_pixel_value,
   output logic                  empty,
   input  logic                  pop,
   output logic [ROW2_W-1:0]     rsp_start_row2,
   output logic [COL2_W-1:0]     rsp_start_col2,
   output logic [ROW2_W-1:0]     rsp_end_row2,
   output logic [COL2_W-1:0]     rsp_end_col2,
   output logic                  rsp_last_of_cell,
   input  logic                  valid,
   output logic                  ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int CELL_W = ROW_W + COL_W + 4;

   csr_write_type           csr_write;
   logic                    cell_push;
   logic [CELL_W-1:0]       cell_data;
   logic                    cell_pop;
   logic [CELL_W-1:0]       cell_head;
   logic [CELL_Q_LVL_W-1:0] q_level;

   assign ready           = 1'b1;
   assign csr_write.valid = valid;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_data;

   bcse_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pixel_value (req_pixel_value),
      .full        (full),
      .csr_write   (csr_write),
      .q_level     (q_level),
      .cell_push   (cell_push),
      .cell_data   (cell_data)
   );

   bcse_fifo #(
      .WIDTH (CELL_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cell_push),
      .push_data (cell_data),
      .pop       (cell_pop),
      .pop_data  (cell_head),
      .level     (q_level)
   );

   bcse_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_level != '0),
      .q_data       (cell_head),
      .q_pop        (cell_pop),
      .empty        (empty),
      .pop          (pop),
      .start_row2   (rsp_start_row2),
      .start_col2   (rsp_start_col2),
      .end_row2     (rsp_end_row2),
      .end_col2     (rsp_end_col2),
      .last_of_cell (rsp_last_of_cell)
   );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the contour segment extractor unit.
// ----------------------------------------------------------------------------
// Pixels are pushed column-major. A bit-level model of the marching-squares
// cell logic runs on every accepted pixel and queues the segments it expects.
// A result process pops segments under random stalls and compares every
// field against the oldest queued segment. Image sizes are changed between
// phases once the unit has drained, including mid-image and out-of-range
// sizes, so that clamping and counter wrap are exercised.
// ----------------------------------------------------------------------------
module tb;
   import bcse_pkg::*;

   localparam int ROW_IDX_W = $clog2(DEF_MAX_ROWS);

   typedef struct packed {
      logic [ROW2_W-1:0] start_row2;
      logic [COL2_W-1:0] start_col2;
      logic [ROW2_W-1:0] end_row2;
      logic [COL2_W-1:0] end_col2;
      logic              last_of_cell;
   } segment_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [PIXEL_W-1:0]    req_pixel_value = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [ROW2_W-1:0]     rsp_start_row2;
   logic [COL2_W-1:0]     rsp_start_col2;
   logic [ROW2_W-1:0]     rsp_end_row2;
   logic [COL2_W-1:0]     rsp_end_col2;
   logic                  rsp_last_of_cell;
   logic                  valid = 1'b0;
   logic                  ready;
   csr_index_type         csr_index = CSR_IMAGE_ROWS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   binary_contour_segment_extractor_unit uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_pixel_value  (req_pixel_value),
      .empty            (empty),
      .pop              (pop),
      .rsp_start_row2   (rsp_start_row2),
      .rsp_start_col2   (rsp_start_col2),
      .rsp_end_row2     (rsp_end_row2),
      .rsp_end_col2     (rsp_end_col2),
      .rsp_last_of_cell (rsp_last_of_cell),
      .valid            (valid),
      .ready            (ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // cell model state
   bit                    col_store [DEF_MAX_ROWS];
   int unsigned           rows_seen = 0;
   int unsigned           row_idx = 0;
   int unsigned           col_idx = 0;
   bit                    left_above = 1'b0;
   bit                    above = 1'b0;
   bit [ROWS_CFG_W-1:0]   cfg_rows = ROWS_CFG_W'(RST_IMAGE_ROWS);
   bit [COLS_CFG_W-1:0]   cfg_cols = COLS_CFG_W'(RST_IMAGE_COLS);

   segment_type           pending_segments [$];
   segment_type           want;
   int unsigned           mismatches = 0;
   int unsigned           segments_seen = 0;
   int unsigned           pixels_sent = 0;
   int unsigned           size_settings = 0;

   // idle odds, 1 in n per beat; 0 turns idling off
   int unsigned           push_odds = 0;
   int unsigned           pop_odds = 0;
   int unsigned           pop_hold = 0;

   function automatic int unsigned size_of(input int unsigned v, input int unsigned top);
      if (v < 2) return 2;
      if (v > top) return top;
      return v;
   endfunction

   // growing the row count mid-image must not expose store entries never written
   function automatic bit rows_safe(input logic [CSR_DATA_W-1:0] raw);
      int unsigned rows;
      rows = size_of(32'(raw[ROWS_CFG_W-1:0]), DEF_MAX_ROWS);
      return (col_idx == 0) || (rows <= rows_seen);
   endfunction

   function automatic logic [PIXEL_W-1:0] gen_pixel(input int unsigned ink);
      if ($urandom_range(0, 15) < ink) return PIXEL_W'($urandom_range(1, 255));
      return '0;
   endfunction

   function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic march_pixel(input logic [PIXEL_W-1:0] pix);
      int unsigned       rows, cols, r, c, n;
      bit                cur, left, open;
      logic [ROW2_W-1:0] mid_row [4];
      logic [COL2_W-1:0] mid_col [4];
      bit                crossed [4];
      logic [ROW2_W-1:0] from_row;
      logic [COL2_W-1:0] from_col;
      segment_type       seg [2];
      rows = size_of(32'(cfg_rows), DEF_MAX_ROWS);
      cols = size_of(32'(cfg_cols), DEF_MAX_COLS);
      r = row_idx;
      c = col_idx;
      cur = (pix != 0);
      left = col_store[ROW_IDX_W'(r)];
      n = 0;
      open = 1'b0;
      from_row = '0;
      from_col = '0;
      if (r >= 1 && c >= 1) begin
         mid_row[EDGE_TOP]    = ROW2_W'(2 * r - 2);
         mid_col[EDGE_TOP]    = COL2_W'(2 * c - 1);
         mid_row[EDGE_RIGHT]  = ROW2_W'(2 * r - 1);
         mid_col[EDGE_RIGHT]  = COL2_W'(2 * c);
         mid_row[EDGE_BOTTOM] = ROW2_W'(2 * r);
         mid_col[EDGE_BOTTOM] = COL2_W'(2 * c - 1);
         mid_row[EDGE_LEFT]   = ROW2_W'(2 * r - 1);
         mid_col[EDGE_LEFT]   = COL2_W'(2 * c - 2);
         crossed[EDGE_TOP]    = left_above ^ above;
         crossed[EDGE_RIGHT]  = above ^ cur;
         crossed[EDGE_BOTTOM] = cur ^ left;
         crossed[EDGE_LEFT]   = left ^ left_above;
         // crossings pair up in edge order, so a saddle closes two segments
         for (int e = 0; e < 4; e++) begin
            if (crossed[2'(e)]) begin
               if (!open) begin
                  from_row = mid_row[2'(e)];
                  from_col = mid_col[2'(e)];
                  open = 1'b1;
               end else begin
                  seg[1'(n)].start_row2   = from_row;
                  seg[1'(n)].start_col2   = from_col;
                  seg[1'(n)].end_row2     = mid_row[2'(e)];
                  seg[1'(n)].end_col2     = mid_col[2'(e)];
                  seg[1'(n)].last_of_cell = 1'b0;
                  n++;
                  open = 1'b0;
               end
            end
         end
         if (n > 0) seg[1'(n - 1)].last_of_cell = 1'b1;
         for (int k = 0; k < n; k++) pending_segments.push_back(seg[1'(k)]);
      end
      col_store[ROW_IDX_W'(r)] = cur;
      if (r + 1 > rows_seen) rows_seen = r + 1;
      left_above = left;
      above = cur;
      if (r + 1 >= rows) begin
         row_idx = 0;
         col_idx = (c + 1 >= cols) ? 0 : c + 1;
      end else begin
         row_idx = r + 1;
      end
      pixels_sent++;
   endtask

   // push stays high into the next send, so back-to-back beats never drop it
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
      req_pixel_value <= pix;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      march_pixel(pix);
      if (push_odds != 0 && $urandom_range(0, push_odds - 1) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_for_segments();
      push <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      // pixels that close no cell may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data <= data;
      valid <= 1'b1;
      @(posedge clock);
      while (!ready) @(posedge clock);
      case (idx)
         CSR_IMAGE_ROWS: cfg_rows = data[ROWS_CFG_W-1:0];
         CSR_IMAGE_COLS: cfg_cols = data[COLS_CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_size(input logic [CSR_DATA_W-1:0] rows_raw,
                               input logic [CSR_DATA_W-1:0] cols_raw);
      if (!rows_safe(rows_raw)) rows_raw = CSR_DATA_W'(cfg_rows);
      write_reg(CSR_IMAGE_ROWS, rows_raw);
      write_reg(CSR_IMAGE_COLS, cols_raw);
      valid <= 1'b0;
      size_settings++;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_size(input int unsigned small_hi);
      case ($urandom_range(0, 9))
         0: return CSR_DATA_W'($urandom_range(0, 1));
         1: return CSR_DATA_W'($urandom_range(0, 8191));
         default: return CSR_DATA_W'($urandom_range(2, small_hi));
      endcase
   endfunction

   // result side: pop with random stall bursts, check each beat taken
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_hold = 0;
      end else begin
         if (pop && !empty) begin
            if (pending_segments.size() == 0) begin
               $error("segment beat arrived with none expected");
               mismatches++;
            end else begin
               want = pending_segments.pop_front();
               segments_seen++;
               if (!field_ok("start_row2", 32'(want.start_row2), 32'(rsp_start_row2)))
                  mismatches++;
               if (!field_ok("start_col2", 32'(want.start_col2), 32'(rsp_start_col2)))
                  mismatches++;
               if (!field_ok("end_row2", 32'(want.end_row2), 32'(rsp_end_row2)))
                  mismatches++;
               if (!field_ok("end_col2", 32'(want.end_col2), 32'(rsp_end_col2)))
                  mismatches++;
               if (!field_ok("last_of_cell", 32'(want.last_of_cell),
                             32'(rsp_last_of_cell)))
                  mismatches++;
            end
         end
         if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
         end else if (pop_odds != 0 && $urandom_range(0, pop_odds - 1) == 0) begin
            pop_hold = $urandom_range(1, 8) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // reset sizes: everything lands in column 0, no cell closes
   task automatic test_reset_column();
      push_odds = 6;
      pop_odds = 6;
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h01);
      send_pixel(8'h80);
      wait_for_segments();
   endtask

   // two-row image written mid-column: the row counter sits past the new
   // last row and wraps after one more pixel; then saddles both ways,
   // single segments, an empty cell and an image wrap
   task automatic test_cell_cases();
      program_size(13'd2, 13'd6);
      send_pixel(8'h7E);
      send_pixel(8'h02); send_pixel(8'h00);   // col 1 (1,0) after (0,1): saddle
      send_pixel(8'h00); send_pixel(8'h40);   // col 2 (0,1): saddle
      send_pixel(8'h04); send_pixel(8'h00);   // col 3 (1,0): saddle
      send_pixel(8'h08); send_pixel(8'h10);   // col 4 (1,1): one segment
      send_pixel(8'h00); send_pixel(8'h00);   // col 5 (0,0): one segment
      send_pixel(8'h20); send_pixel(8'hFF);   // new image, col 0
      send_pixel(8'h55); send_pixel(8'hAA);   // col 1, no crossing
      send_pixel(8'h00); send_pixel(8'h00);   // col 2 (0,0): one segment
      wait_for_segments();
   endtask

   // sizes above range clamp to the largest: a long first column; then both
   // sizes below range mid-column, so the row counter wraps early
   task automatic test_clamped_sizes();
      push_odds = 16;
      pop_odds = 16;
      while (row_idx != 0 || col_idx != 0) send_pixel(gen_pixel(8));
      wait_for_segments();
      program_size(13'h07FF, 13'h1FFF);
      repeat (200) send_pixel(gen_pixel($urandom_range(2, 14)));
      wait_for_segments();
      program_size(13'd1, 13'd0);
      while (row_idx != 0 || col_idx != 0) send_pixel(gen_pixel($urandom_range(2, 14)));
      repeat (40) send_pixel(gen_pixel($urandom_range(2, 14)));
      wait_for_segments();
   endtask

   task automatic test_random_sizes();
      int unsigned n;
      int unsigned odds_pick [3];
      odds_pick[0] = 0;
      odds_pick[1] = 3;
      odds_pick[2] = 12;
      for (int phase = 0; phase < 8; phase++) begin
         program_size(pick_size(9), pick_size(9));
         push_odds = odds_pick[$urandom_range(0, 2)];
         pop_odds = odds_pick[$urandom_range(0, 2)];
         n = $urandom_range(60, 140);
         for (int i = 0; i < n; i++) begin
            send_pixel(gen_pixel(phase % 16 + 1));
            if (i == n / 2 && $urandom_range(0, 2) == 0) wait_for_segments();
         end
         wait_for_segments();
      end
   endtask

   // back-to-back beats on both sides with no idling at all
   task automatic test_steady_stream();
      push_odds = 0;
      pop_odds = 0;
      program_size(CSR_DATA_W'($urandom_range(2, 6)), CSR_DATA_W'($urandom_range(3, 8)));
      repeat (200) send_pixel(gen_pixel(8));
      wait_for_segments();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_column();
      test_cell_cases();
      test_clamped_sizes();
      test_random_sizes();
      test_steady_stream();
      repeat (10) @(posedge clock);
      $display("run covered %0d pixels and %0d segment beats over %0d image sizes",
               pixels_sent, segments_seen, size_settings);
      $display("sizes included clamped and mid-image settings; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_segments.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d segments outstanding", pending_segments.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
